FILE: sv/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared widths, register indexes and types of the Laplace stencil relaxation.
// ----------------------------------------------------------------------------
package lsr_pkg;

   // value and result widths
   localparam int VAL_W        = 32;
   localparam int RES_W        = 63;
   localparam int SQ_W         = 48;
   localparam int ROW_W        = 16;
   localparam int CFG_COLS_W   = 11;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int MIN_DIM      = 3;
   localparam int DEF_MAX_COLS = 1024;

   // register indexes of the write port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWEEP_MODE = 2'd0,
      CSR_GRID_ROWS  = 2'd1,
      CSR_GRID_COLS  = 2'd2
   } csr_index_type;

   // live configuration handed to the datapath
   typedef struct packed {
      logic                  sweep_mode;
      logic [ROW_W-1:0]      grid_rows;
      logic [CFG_COLS_W-1:0] grid_cols;
   } cfg_type;

   // one emitted point between the stencil and the residual stages
   typedef struct packed {
      logic signed [VAL_W-1:0] new_value;
      logic signed [VAL_W-1:0] old_value;
      logic                    interior;
      logic                    done;
   } pt_type;

endpackage

FILE: sv/lsr_ram.sv
// ----------------------------------------------------------------------------
// lsr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lsr_stencil.sv
// ----------------------------------------------------------------------------
// lsr_stencil
// Position counters, row buffers and the four-neighbour quarter sum.
// ----------------------------------------------------------------------------
module lsr_stencil import lsr_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   localparam int COL_W = $clog2(MAX_COLS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_cell_value,
   output logic                    pt_valid,
   input  logic                    pt_ready,
   output pt_type                  pt
);

   localparam int CMP_W = (COL_W + 1 > CFG_COLS_W) ? COL_W + 1 : CFG_COLS_W;

   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    v1_ff, emit1_ff, int1_ff, done1_ff;
   logic signed [VAL_W-1:0] x1_ff;
   logic [COL_W-1:0]        c1_ff;
   logic                    v2_ff;
   pt_type                  pt2_ff;
   logic signed [VAL_W-1:0] left_ff, left_in;

   logic                    s1_en, s2_en, accept, advance1;
   logic [CMP_W-1:0]        cols_cmp;
   logic [COL_W:0]          cols_eff;
   logic [ROW_W-1:0]        rows_eff;
   logic                    last_col, last_row;
   logic [COL_W-1:0]        col_next_addr;
   logic [VAL_W-1:0]        mid_a_rd, mid_b_rd, up_rd;
   logic signed [VAL_W+1:0] sum;
   logic signed [VAL_W-1:0] nv, fb;

   // handshake: each stage moves when the next one is empty or moving
   assign s2_en     = !v2_ff || pt_ready;
   assign s1_en     = !v1_ff || s2_en;
   assign req_ready = s1_en;
   assign accept    = req_valid && s1_en;
   assign advance1  = v1_ff && s2_en;

   // grid size clamped to the legal range
   always_comb begin
      cols_cmp = CMP_W'(cfg.grid_cols);
      if (cols_cmp < CMP_W'(MIN_DIM)) begin
         cols_eff = (COL_W + 1)'(MIN_DIM);
      end else if (cols_cmp > CMP_W'(MAX_COLS)) begin
         cols_eff = (COL_W + 1)'(MAX_COLS);
      end else begin
         cols_eff = (COL_W + 1)'(cols_cmp);
      end
      rows_eff = (cfg.grid_rows < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.grid_rows;
   end

   assign last_col = {1'b0, col_ff} >= (cols_eff - (COL_W + 1)'(1));
   assign last_row = row_ff >= (rows_eff - ROW_W'(1));

   // position of the next item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   assign col_next_addr = (col_ff == COL_W'(MAX_COLS - 1)) ? '0 : col_ff + COL_W'(1);

   // previous row, one copy per read column
   lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_mid_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_cell_value),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_a_rd)
   );

   lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_mid_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_cell_value),
      .rd_en   (accept),
      .rd_addr (col_next_addr),
      .rd_data (mid_b_rd)
   );

   // row two above, old or updated values depending on the mode
   lsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_up (
      .clock   (clock),
      .wr_en   (advance1 && emit1_ff),
      .wr_addr (c1_ff),
      .wr_data (fb),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   // quarter of the neighbour sum, floor by arithmetic shift
   assign sum = (VAL_W + 2)'(left_ff)
              + (VAL_W + 2)'(signed'(mid_b_rd))
              + (VAL_W + 2)'(signed'(up_rd))
              + (VAL_W + 2)'(x1_ff);
   assign nv      = int1_ff ? sum[VAL_W+1:2] : signed'(mid_a_rd);
   assign fb      = cfg.sweep_mode ? nv : signed'(mid_a_rd);
   assign left_in = done1_ff ? '0 : fb;

   // counters, valid bits and left neighbour feedback
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         left_ff <= '0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_en) begin
            v1_ff <= req_valid;
         end
         if (s2_en) begin
            v2_ff <= v1_ff && emit1_ff;
         end
         if (advance1 && emit1_ff) begin
            left_ff <= left_in;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         x1_ff    <= req_cell_value;
         c1_ff    <= col_ff;
         emit1_ff <= row_ff != '0;
         int1_ff  <= (row_ff >= ROW_W'(2)) && (col_ff != '0) && !last_col;
         done1_ff <= last_row && last_col;
      end
      if (s2_en) begin
         pt2_ff.new_value <= nv;
         pt2_ff.old_value <= signed'(mid_a_rd);
         pt2_ff.interior  <= int1_ff;
         pt2_ff.done      <= done1_ff;
      end
   end

   assign pt_valid = v2_ff;
   assign pt       = pt2_ff;

endmodule

FILE: sv/lsr_resid.sv
// ----------------------------------------------------------------------------
// lsr_resid
// Squared change, saturating residual sum and the result register.
// ----------------------------------------------------------------------------
module lsr_resid import lsr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pt_valid,
   output logic                    pt_ready,
   input  pt_type                  pt,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_new_value,
   output logic [RES_W-1:0]        rsp_residual,
   output logic                    rsp_sweep_done
);

   logic                    v3_ff, v4_ff, out_v_ff;
   logic [VAL_W-1:0]        mag_ff;
   logic signed [VAL_W-1:0] nv3_ff, nv4_ff, out_nv_ff;
   logic                    int3_ff, int4_ff, done3_ff, done4_ff, out_done_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [RES_W-1:0]        acc_ff, acc_in, out_res_ff;

   logic                    out_en, s4_en, s3_en, advance4;
   logic signed [VAL_W:0]   diff;
   logic [VAL_W:0]          mag;
   logic [2*VAL_W-1:0]      prod;
   logic [RES_W:0]          acc_sum;

   // handshake
   assign out_en   = !out_v_ff || rsp_ready;
   assign s4_en    = !v4_ff || out_en;
   assign s3_en    = !v3_ff || s4_en;
   assign pt_ready = s3_en;
   assign advance4 = v4_ff && out_en;

   // magnitude of the change, fits in the value width
   assign diff = (VAL_W + 1)'(pt.new_value) - (VAL_W + 1)'(pt.old_value);
   assign mag  = diff[VAL_W] ? (VAL_W + 1)'(-diff) : (VAL_W + 1)'(diff);

   // square truncated to Q32.16
   assign prod = (2 * VAL_W)'(mag_ff) * (2 * VAL_W)'(mag_ff);

   // saturating accumulate of interior points
   assign acc_sum = (RES_W + 1)'(acc_ff) + (RES_W + 1)'(sq_ff);
   always_comb begin
      acc_in = acc_ff;
      if (int4_ff) begin
         acc_in = acc_sum[RES_W] ? '1 : acc_sum[RES_W-1:0];
      end
   end

   // valid bits and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (s3_en) begin
            v3_ff <= pt_valid;
         end
         if (s4_en) begin
            v4_ff <= v3_ff;
         end
         if (out_en) begin
            out_v_ff <= v4_ff;
         end
         if (advance4) begin
            acc_ff <= done4_ff ? '0 : acc_in;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s3_en) begin
         mag_ff   <= mag[VAL_W-1:0];
         nv3_ff   <= pt.new_value;
         int3_ff  <= pt.interior;
         done3_ff <= pt.done;
      end
      if (s4_en) begin
         sq_ff    <= prod[2*VAL_W-1:2*VAL_W-SQ_W];
         nv4_ff   <= nv3_ff;
         int4_ff  <= int3_ff;
         done4_ff <= done3_ff;
      end
      if (out_en) begin
         out_nv_ff   <= nv4_ff;
         out_res_ff  <= acc_in;
         out_done_ff <= done4_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_new_value  = out_nv_ff;
   assign rsp_residual   = out_res_ff;
   assign rsp_sweep_done = out_done_ff;

endmodule

FILE: sv/laplace_stencil_relaxation.sv
// Path: an item passes stage one, stage two, the magnitude and square stages, then the output register.
// Throughput: one item per cycle unless the output stalls; the left neighbour add sets it.
// Results lag one grid row; items of the first row give no result.
// Reset (synchronous, active high) clears counters, valid bits, residual and configuration registers.
// Row buffers are not cleared and are written before their contents are used.
// ----------------------------------------------------------------------------
// laplace_stencil_relaxation
// One Jacobi or Gauss-Seidel sweep of a streamed grid with a residual sum.
// ----------------------------------------------------------------------------
module laplace_stencil_relaxation import lsr_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_cell_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_new_value,
   output logic [RES_W-1:0]        rsp_residual,
   output logic                    rsp_sweep_done
);

   cfg_type cfg_ff;
   logic    pt_valid, pt_ready;
   pt_type  pt;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_mode <= 1'b0;
         cfg_ff.grid_rows  <= ROW_W'(MIN_DIM);
         cfg_ff.grid_cols  <= CFG_COLS_W'(MIN_DIM);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SWEEP_MODE: cfg_ff.sweep_mode <= csr_wr_data[0];
            CSR_GRID_ROWS:  cfg_ff.grid_rows  <= csr_wr_data[ROW_W-1:0];
            CSR_GRID_COLS:  cfg_ff.grid_cols  <= csr_wr_data[CFG_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // neighbour sum and row buffers
   lsr_stencil #(.MAX_COLS(MAX_COLS)) u_stencil (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_value (req_cell_value),
      .pt_valid       (pt_valid),
      .pt_ready       (pt_ready),
      .pt             (pt)
   );

   // residual and result register
   lsr_resid u_resid (
      .clock          (clock),
      .reset          (reset),
      .pt_valid       (pt_valid),
      .pt_ready       (pt_ready),
      .pt             (pt),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_value  (rsp_new_value),
      .rsp_residual   (rsp_residual),
      .rsp_sweep_done (rsp_sweep_done)
   );

endmodule
